/* design/cleb_pkg.sv */
`default_nettype none

package cleb_pkg;

    // default line capacity in bytes
    localparam int CAPACITY_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_LEFT   = 3'd2;
    localparam logic [2:0] OP_RIGHT  = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_DELETE = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // printable range for append
    localparam logic [7:0] PRINT_LO = 8'd33;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // datapath actions issued by the controller
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_CLEAR,
        ACT_APPEND,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_READ,
        ACT_INS_START,
        ACT_INS_SHIFT,
        ACT_INS_PUT,
        ACT_DEL_START,
        ACT_DEL_SHIFT,
        ACT_DEL_END,
        ACT_FINISH
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [1:0] status;
    } cleb_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       printable;
        logic       full;
        logic       pos_valid;
        logic       can_right;
        logic       rd_ok;
        logic       at_end;
        logic       ins_last;
        logic       del_last;
    } cleb_stat_t;

endpackage

`default_nettype wire

/* design/cleb_datapath.sv */
`default_nettype none

module cleb_datapath #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cleb_pkg::cleb_cmd_t  cmd,
    output cleb_pkg::cleb_stat_t      stat,
    input  wire logic [2:0]       op,
    input  wire logic [7:0]       ch,
    input  wire logic [5:0]       read_index,
    output logic [1:0]            status,
    output logic [7:0]            out_char,
    output logic [6:0]            length,
    output logic [6:0]            cursor
);
    import cleb_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 6;

    logic [7:0]    mem [CAPACITY];

    logic [2:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [5:0]    ridx_reg;
    logic [CW-1:0] count_reg, count_next;
    // cursor plus one, so zero means before the first byte
    logic [CW-1:0] posp1_reg, posp1_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0]    rdata_reg;
    logic [1:0]    res_status_reg;
    logic [7:0]    res_char_reg;
    logic [6:0]    res_len_reg;
    logic [6:0]    res_cur_reg;

    logic          wen, ren;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;

    // status towards the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.printable = (ch_reg >= PRINT_LO) && (ch_reg <= PRINT_HI);
        stat.full      = (count_reg == CW'(CAPACITY));
        stat.pos_valid = (posp1_reg != '0);
        stat.can_right = (posp1_reg < count_reg);
        stat.rd_ok     = (XW'(ridx_reg) < XW'(count_reg));
        stat.at_end    = (posp1_reg == count_reg);
        stat.ins_last  = ((idx_reg - 1'b1) == posp1_reg);
        stat.del_last  = ((idx_reg + CW'(2)) == count_reg);
    end

    // memory port control
    always_comb
    begin
        wen   = 1'b0;
        ren   = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = ch_reg;
        case (cmd.act)
            ACT_APPEND:
            begin
                wen   = 1'b1;
                waddr = AW'(count_reg);
            end
            ACT_INS_START:
            begin
                ren   = 1'b1;
                raddr = AW'(count_reg - 1'b1);
            end
            ACT_INS_SHIFT:
            begin
                wen   = 1'b1;
                waddr = AW'(idx_reg);
                wdata = rdata_reg;
                ren   = 1'b1;
                raddr = AW'(idx_reg - CW'(2));
            end
            ACT_INS_PUT:
            begin
                wen   = 1'b1;
                waddr = AW'(posp1_reg);
            end
            ACT_DEL_START:
            begin
                ren   = 1'b1;
                raddr = AW'(posp1_reg);
            end
            ACT_DEL_SHIFT:
            begin
                wen   = 1'b1;
                waddr = AW'(idx_reg);
                wdata = rdata_reg;
                ren   = 1'b1;
                raddr = AW'(idx_reg + CW'(2));
            end
            ACT_READ:
            begin
                ren   = 1'b1;
                raddr = AW'(ridx_reg);
            end
            default:
            begin
                wen = 1'b0;
            end
        endcase
    end

    // length, cursor and shift index updates
    always_comb
    begin
        count_next = count_reg;
        posp1_next = posp1_reg;
        idx_next   = idx_reg;
        case (cmd.act)
            ACT_CLEAR:
            begin
                count_next = '0;
                posp1_next = '0;
            end
            ACT_APPEND:
            begin
                count_next = count_reg + 1'b1;
                posp1_next = count_reg + 1'b1;
            end
            ACT_LEFT:      posp1_next = posp1_reg - 1'b1;
            ACT_RIGHT:     posp1_next = posp1_reg + 1'b1;
            ACT_INS_START: idx_next   = count_reg;
            ACT_INS_SHIFT: idx_next   = idx_reg - 1'b1;
            ACT_INS_PUT:
            begin
                count_next = count_reg + 1'b1;
                posp1_next = posp1_reg + 1'b1;
            end
            ACT_DEL_START: idx_next   = posp1_reg - 1'b1;
            ACT_DEL_SHIFT: idx_next   = idx_reg + 1'b1;
            ACT_DEL_END:
            begin
                count_next = count_reg - 1'b1;
                posp1_next = posp1_reg - 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            posp1_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            posp1_reg <= posp1_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.act == ACT_LOAD)
        begin
            op_reg   <= op;
            ch_reg   <= ch;
            ridx_reg <= read_index;
        end
        if (cmd.act == ACT_FINISH)
        begin
            res_status_reg <= cmd.status;
            res_char_reg   <= (op_reg == OP_READ && cmd.status == ST_DONE) ? rdata_reg : 8'd0;
            res_len_reg    <= 7'(count_reg);
            res_cur_reg    <= 7'(posp1_reg) - 7'd1;
        end
    end

    // text store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign status   = res_status_reg;
    assign out_char = res_char_reg;
    assign length   = res_len_reg;
    assign cursor   = res_cur_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("length beyond capacity");
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        posp1_reg <= count_reg)
        else $error("cursor beyond last byte");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.act == ACT_INS_PUT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the line");
`endif

endmodule

`default_nettype wire

/* design/cleb_ctrl.sv */
`default_nettype none

module cleb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire cleb_pkg::cleb_stat_t stat,
    output cleb_pkg::cleb_cmd_t       cmd
);
    import cleb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_DEL_END,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.act       = ACT_NONE;
        cmd.status    = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.act    = ACT_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_DONE;
                status_next = ST_DONE;
                case (stat.op)
                    OP_CLEAR:  cmd.act = ACT_CLEAR;
                    OP_APPEND:
                    begin
                        if (!stat.printable)
                        begin
                            status_next = ST_IGNORED;
                        end
                        else if (stat.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.act = ACT_APPEND;
                        end
                    end
                    OP_LEFT:
                    begin
                        if (stat.pos_valid)
                        begin
                            cmd.act = ACT_LEFT;
                        end
                        else
                        begin
                            status_next = ST_IGNORED;
                        end
                    end
                    OP_RIGHT:
                    begin
                        if (stat.can_right)
                        begin
                            cmd.act = ACT_RIGHT;
                        end
                        else
                        begin
                            status_next = ST_IGNORED;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.act    = ACT_INS_START;
                            state_next = stat.at_end ? S_INS_PUT : S_INS_SHIFT;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.pos_valid)
                        begin
                            cmd.act    = ACT_DEL_START;
                            state_next = stat.at_end ? S_DEL_END : S_DEL_SHIFT;
                        end
                        else
                        begin
                            status_next = ST_IGNORED;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.rd_ok)
                        begin
                            cmd.act = ACT_READ;
                        end
                        else
                        begin
                            status_next = ST_IGNORED;
                        end
                    end
                    default:
                    begin
                        status_next = ST_IGNORED;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                cmd.act = ACT_INS_SHIFT;
                if (stat.ins_last)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.act    = ACT_INS_PUT;
                state_next = S_DONE;
            end
            S_DEL_SHIFT:
            begin
                cmd.act = ACT_DEL_SHIFT;
                if (stat.del_last)
                begin
                    state_next = S_DEL_END;
                end
            end
            S_DEL_END:
            begin
                cmd.act    = ACT_DEL_END;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to drain
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.act       = ACT_FINISH;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            status_reg   <= ST_DONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* design/cursor_line_edit_buffer.sv */
// channel  | dir | tdata (lsb first)                                  | width
// s_axis   | in  | op[2:0] ch[10:3] read_index[16:11] zero[23:17]     | 24
// m_axis   | out | status[1:0] out_char[9:2] length[16:10] cursor[23:17] | 24
//
// one edit at a time; clear, append, move and read go from the exec state
// to the done state, while insert and delete first shift the text store
// byte by byte through their shift states (none when the cursor is at the end)
// the next beat is taken while a result still waits in the output register
// reset clears length and cursor (to before the first byte); text store
// contents are not cleared and no clearing pass runs
`default_nettype none

module cursor_line_edit_buffer #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // op, ch, read_index, zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // status, out_char, length, cursor
);
    import cleb_pkg::*;

    cleb_cmd_t  cmd;
    cleb_stat_t stat;

    logic [1:0] status;
    logic [7:0] out_char;
    logic [6:0] length;
    logic [6:0] cursor;

    // sequencer: decodes the held beat and steps insert and delete shifts
    cleb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // text store, length, cursor and the result register
    cleb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (s_axis_tdata[2:0]),
        .ch         (s_axis_tdata[10:3]),
        .read_index (s_axis_tdata[16:11]),
        .status     (status),
        .out_char   (out_char),
        .length     (length),
        .cursor     (cursor)
    );

    // result beat packed lowest field first
    assign m_axis_tdata = {cursor, length, out_char, status};

endmodule

`default_nettype wire

/* verif/tb_cursor_line_edit_buffer.sv */
module tb_cursor_line_edit_buffer;

    timeunit 1ns;
    timeprecision 1ps;

    import cleb_pkg::*;

    // line capacity of the instance under test (default parameter)
    localparam int LINE_CAP     = CAPACITY_DEF;
    // op 7 has no meaning and must be ignored
    localparam logic [2:0] OP_BAD = 3'd7;

    localparam int RANDOM_EDITS = 1200;
    // no idling on either side for the last stretch of the run
    localparam int QUIET_TAIL   = 150;
    // random beat after which the receiver holds off for a long stretch
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    // long enough for the worst insert or delete, plus some slack
    localparam int DRAIN_CYCLES = LINE_CAP + 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ROWS         = 25;

    // result beat as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [6:0] cursor;
        logic [6:0] length;
        logic [7:0] out_char;
        logic [1:0] status;
    } line_result_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [2:0]   op;
        logic [7:0]   ch;
        logic [5:0]   idx;
        bit           typed;
        line_result_t want;
    } edit_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    // shadow copy of the line and the cursor
    logic [7:0]   line_text [LINE_CAP];
    int           text_len;
    int           edit_cursor;

    line_result_t pending_results [$];
    line_result_t got_res;
    line_result_t want_res;

    edit_row_t    edit_rows [ROWS];

    int  edits_sent;
    int  results_seen;
    int  mismatches;
    int  full_drops;
    int  ignored_seen;
    int  cycle_count;
    int  long_holds_asked;
    int  long_holds_done;
    int  rx_wait;
    bit  tx_idle_on;
    bit  rx_stall_on;

    cursor_line_edit_buffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run-away guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("cursor_line_edit_buffer regression: fail");
        $finish;
    end

    function automatic line_result_t result_of(input logic [1:0] st, input logic [7:0] oc,
                                               input int len, input int cur);
        line_result_t r;
        r.status   = st;
        r.out_char = oc;
        r.length   = 7'(len);
        r.cursor   = 7'(cur);
        return r;
    endfunction

    // applies one edit to the shadow line and returns the beat it should give
    function automatic line_result_t apply_edit(input logic [2:0] op, input logic [7:0] ch,
                                                input logic [5:0] idx);
        line_result_t r;
        int           at;
        r        = '0;
        r.status = ST_DONE;
        case (op)
            OP_CLEAR:
            begin
                text_len    = 0;
                edit_cursor = -1;
            end
            OP_APPEND:
            begin
                if (ch < PRINT_LO || ch > PRINT_HI)
                    r.status = ST_IGNORED;
                else if (text_len >= LINE_CAP)
                    r.status = ST_FULL;
                else
                begin
                    line_text[text_len] = ch;
                    text_len++;
                    edit_cursor = text_len - 1;
                end
            end
            OP_LEFT:
            begin
                if (edit_cursor >= 0)
                    edit_cursor--;
                else
                    r.status = ST_IGNORED;
            end
            OP_RIGHT:
            begin
                // signed compare, so a right move from before the first byte works
                if (edit_cursor + 1 < text_len)
                    edit_cursor++;
                else
                    r.status = ST_IGNORED;
            end
            OP_INSERT:
            begin
                if (text_len >= LINE_CAP)
                    r.status = ST_FULL;
                else
                begin
                    at = edit_cursor + 1;
                    for (int i = text_len; i > at; i--)
                        line_text[i] = line_text[i - 1];
                    line_text[at] = ch;
                    text_len++;
                    edit_cursor++;
                end
            end
            OP_DELETE:
            begin
                if (edit_cursor >= 0 && text_len > 0)
                begin
                    for (int i = edit_cursor; i + 1 < text_len; i++)
                        line_text[i] = line_text[i + 1];
                    text_len--;
                    edit_cursor--;
                end
                else
                    r.status = ST_IGNORED;
            end
            OP_READ:
            begin
                if (int'(idx) < text_len)
                    r.out_char = line_text[idx];
                else
                    r.status = ST_IGNORED;
            end
            default:
                r.status = ST_IGNORED;
        endcase
        r.length = 7'(text_len);
        r.cursor = 7'(edit_cursor);
        return r;
    endfunction

    // offers one beat, waits for the handshake, then queues what should come back
    task automatic send_edit(input logic [2:0] op, input logic [7:0] ch, input logic [5:0] idx,
                             input bit typed, input line_result_t want);
        line_result_t predicted;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, idx, ch, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // shadow state always advances; table rows may override the expectation
        predicted = apply_edit(op, ch, idx);
        pending_results.push_back(typed ? want : predicted);
        edits_sent++;
    endtask

    function automatic logic [2:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:  // grow the line, reaching full often
                return r < 45 ? OP_APPEND : r < 85 ? OP_INSERT : r < 90 ? OP_RIGHT :
                       r < 95 ? OP_LEFT : OP_READ;
            1:  // general editing, with a little noise
                return r < 2 ? OP_BAD : r < 17 ? OP_LEFT : r < 32 ? OP_RIGHT :
                       r < 47 ? OP_INSERT : r < 60 ? OP_DELETE : r < 78 ? OP_READ :
                       r < 93 ? OP_APPEND : OP_READ;
            2:  // shrink the line
                return r < 50 ? OP_DELETE : r < 70 ? OP_LEFT : r < 80 ? OP_RIGHT :
                       r < 95 ? OP_READ : OP_CLEAR;
            default:  // fill to the brim and beyond
                return r < 70 ? OP_APPEND : OP_INSERT;
        endcase
    endfunction

    // stimulus and end of run
    initial
    begin
        int           mode;
        int           span;
        int           random_sent;
        logic [2:0]   op;
        logic [7:0]   ch;
        logic [5:0]   idx;

        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        edits_sent       = 0;
        long_holds_asked = 0;
        tx_idle_on       = 1'b1;
        rx_stall_on      = 1'b1;
        text_len         = 0;
        edit_cursor      = -1;
        random_sent      = 0;

        // directed edits; typed rows are plain corner outcomes, the rest use the shadow
        edit_rows = '{
            '{OP_READ,   8'd0,   6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_LEFT,   8'd0,   6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_RIGHT,  8'd0,   6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_DELETE, 8'd0,   6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_APPEND, 8'd32,  6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_APPEND, 8'd127, 6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 0, -1)},
            '{OP_APPEND, 8'd33,  6'd0,  1'b1, result_of(ST_DONE,    8'd0, 1,  0)},
            '{OP_APPEND, 8'd126, 6'd0,  1'b1, result_of(ST_DONE,    8'd0, 2,  1)},
            '{OP_LEFT,   8'd0,   6'd0,  1'b0, '0},
            '{OP_LEFT,   8'd0,   6'd0,  1'b0, '0},
            '{OP_LEFT,   8'd0,   6'd0,  1'b1, result_of(ST_IGNORED, 8'd0, 2, -1)},
            '{OP_RIGHT,  8'd0,   6'd0,  1'b0, '0},
            '{OP_INSERT, 8'd0,   6'd0,  1'b0, '0},
            '{OP_INSERT, 8'd255, 6'd0,  1'b0, '0},
            '{OP_RIGHT,  8'd0,   6'd0,  1'b0, '0},
            '{OP_RIGHT,  8'd0,   6'd0,  1'b0, '0},
            '{OP_READ,   8'd0,   6'd63, 1'b1, result_of(ST_IGNORED, 8'd0, 4,  3)},
            '{OP_READ,   8'd0,   6'd3,  1'b0, '0},
            '{OP_DELETE, 8'd0,   6'd0,  1'b0, '0},
            '{OP_BAD,    8'd255, 6'd63, 1'b0, '0},
            '{OP_READ,   8'd0,   6'd0,  1'b0, '0},
            '{OP_CLEAR,  8'd0,   6'd0,  1'b1, result_of(ST_DONE,    8'd0, 0, -1)},
            '{OP_INSERT, 8'd65,  6'd0,  1'b0, '0},
            '{OP_APPEND, 8'd0,   6'd0,  1'b0, '0},
            '{OP_APPEND, 8'd255, 6'd0,  1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edit_rows[n])
            send_edit(edit_rows[n].op, edit_rows[n].ch, edit_rows[n].idx,
                      edit_rows[n].typed, edit_rows[n].want);

        // random part in episodes: grow, edit, shrink or fill, with idling mixed per episode
        while (random_sent < RANDOM_EDITS)
        begin
            mode        = $urandom_range(0, 3);
            span        = $urandom_range(20, 90);
            tx_idle_on  = $urandom_range(0, 3) != 0;
            rx_stall_on = $urandom_range(0, 3) != 0;
            for (int k = 0; k < span && random_sent < RANDOM_EDITS; k++)
            begin
                if (random_sent >= RANDOM_EDITS - QUIET_TAIL)
                begin
                    tx_idle_on  = 1'b0;
                    rx_stall_on = 1'b0;
                end
                op = pick_op(mode);
                // appends are mostly printable, inserts take any byte
                if (op == OP_APPEND && $urandom_range(0, 7) != 0)
                    ch = 8'($urandom_range(PRINT_LO, PRINT_HI));
                else
                    ch = 8'($urandom_range(0, 255));
                if (text_len > 0 && $urandom_range(0, 3) != 0)
                    idx = 6'($urandom_range(0, text_len - 1));
                else
                    idx = 6'($urandom_range(0, 63));
                send_edit(op, ch, idx, 1'b0, '0);
                random_sent++;
                if (random_sent == HOLD_AT)
                    long_holds_asked++;
            end
            if (random_sent < RANDOM_EDITS && $urandom_range(0, 4) == 0)
            begin
                send_edit(OP_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                          1'b0, '0);
                random_sent++;
                if (random_sent == HOLD_AT)
                    long_holds_asked++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d edits sent (%0d directed), %0d results checked in %0d cycles",
                 edits_sent, ROWS, results_seen, cycle_count);
        $display("%0d full drops, %0d ignored or bad-index results, %0d mismatches",
                 full_drops, ignored_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("cursor_line_edit_buffer regression: pass");
        else
            $display("cursor_line_edit_buffer regression: fail");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off so the block backs up
    initial
    begin
        m_axis_tready   = 1'b0;
        long_holds_done = 0;
        rx_wait         = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_holds_done != long_holds_asked)
            begin
                long_holds_done++;
                rx_wait = HOLD_CYCLES;
            end
            else if (rx_wait == 0 && rx_stall_on && $urandom_range(0, 5) == 0)
                rx_wait = $urandom_range(1, 13);
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0h with nothing outstanding",
                             m_axis_tdata);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (want_res.status == ST_FULL)
                    full_drops++;
                if (want_res.status == ST_IGNORED)
                    ignored_seen++;
                if (got_res.status !== want_res.status || got_res.out_char !== want_res.out_char
                    || got_res.length !== want_res.length || got_res.cursor !== want_res.cursor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d mismatch (exp/got): status %0d/%0d out_char %02h/%02h",
                                 results_seen, want_res.status, got_res.status,
                                 want_res.out_char, got_res.out_char);
                        $display("    length %0d/%0d cursor %0d/%0d",
                                 want_res.length, got_res.length,
                                 $signed(want_res.cursor), $signed(got_res.cursor));
                    end
                end
            end
        end
    end

endmodule

/* filelist.f */
design/cleb_pkg.sv
design/cleb_datapath.sv
design/cleb_ctrl.sv
design/cursor_line_edit_buffer.sv
verif/tb_cursor_line_edit_buffer.sv
